// File: design/afsk_pkg.sv
// ----------------------------------------------------------------------------
// afsk_pkg
// Shared widths, sizes and register codes of the AFSK sliding-DFT demodulator.
// ----------------------------------------------------------------------------
package afsk_pkg;

  localparam int WINDOW_LEN = 40;
  localparam int POS_W      = $clog2(WINDOW_LEN);
  localparam int FILL_W     = $clog2(WINDOW_LEN);
  localparam int LOOP_GAIN  = 1966;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 24;
  localparam int ROT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int DELAY_W    = 32;
  localparam int BIN_W      = 32;
  localparam int SOFT_W     = 49;
  localparam int PHASE_W    = 26;
  localparam int QUO_W      = 26;
  localparam int DIV_STEPS  = 25;

  localparam logic [COEF_W-1:0] PLL_STEP_RESET = 24'd419430;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPF_GAIN       = 3'd0,
    CFG_BPF_FB_ONE     = 3'd1,
    CFG_BPF_FB_TWO     = 3'd2,
    CFG_MARK_ROTATION  = 3'd3,
    CFG_SPACE_ROTATION = 3'd4,
    CFG_MARK_WRAP_FIX  = 3'd5,
    CFG_SPACE_WRAP_FIX = 3'd6,
    CFG_PLL_STEP       = 3'd7
  } cfg_idx_t;

endpackage

// File: design/afsk_if.sv
// ----------------------------------------------------------------------------
// afsk_if
// Valid/ready channels: audio samples in, decided bits out.
// ----------------------------------------------------------------------------
interface afsk_sample_if;
  logic                               valid;
  logic                               ready;
  logic signed [afsk_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface afsk_bit_if;
  logic valid;
  logic ready;
  logic bit_res;

  modport source (output valid, output bit_res, input ready);
  modport sink   (input valid, input bit_res, output ready);
endinterface

// File: design/afsk_ram.sv
// ----------------------------------------------------------------------------
// afsk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module afsk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/afsk_sdft_demodulator.sv
// ----------------------------------------------------------------------------
// afsk_sdft_demodulator
// Band-pass biquad, two-bin sliding DFT and Gardner bit timing on one shared
// 33x33 multiplier, with the sample window held in a RAM.
// ----------------------------------------------------------------------------
//  channel    dir   handshake            payload
//  samples    in    valid/ready          sample  (16 bit signed)
//  bits       out   valid/ready          bit_res (1 bit)
//  cfg        in    cfg_we               cfg_index (3 bit), cfg_data (48 bit)
//
//  one item runs 25 multiplier steps (filter, four bin updates, four squares)
//  and the loop update, then returns to idle; an item that ends a bit adds the
//  hand-off to the output, and a bit with a timing nudge also adds the 25-step
//  restoring divider and the gain multiply. Samples are accepted only in idle.
//  rst is synchronous; the window reads as zero until its first wrap.
//  a waiting bit stalls the next emit and, with it, acceptance of samples.
// ----------------------------------------------------------------------------
module afsk_sdft_demodulator (
  input  logic                               clk,
  input  logic                               rst,
  afsk_sample_if.sink                        samples,
  afsk_bit_if.source                         bits,
  input  logic                               cfg_we,
  input  logic [afsk_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [afsk_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int L      = afsk_pkg::WINDOW_LEN;
  localparam int POS_W  = afsk_pkg::POS_W;
  localparam int FILL_W = afsk_pkg::FILL_W;

  localparam logic [4:0] STEP_W    = 5'd3;
  localparam logic [4:0] STEP_Y    = 5'd6;
  localparam logic [4:0] STEP_MRE  = 5'd11;
  localparam logic [4:0] STEP_MIM  = 5'd14;
  localparam logic [4:0] STEP_SRE  = 5'd17;
  localparam logic [4:0] STEP_SIM  = 5'd20;
  localparam logic [4:0] STEP_SOFT = 5'd24;
  localparam logic [4:0] DIV_LAST  = 5'(afsk_pkg::DIV_STEPS - 1);
  localparam logic [15:0] GAIN     = 16'(afsk_pkg::LOOP_GAIN);

  localparam logic signed [26:0] HALF_Q24 = 27'sd8388608;
  localparam logic signed [26:0] ONE_Q24  = 27'sd16777216;

  typedef enum logic [2:0] {ST_IDLE, ST_RUN, ST_LOOP, ST_DIV, ST_CORR, ST_EMIT} state_t;
  typedef enum logic [1:0] {OP_NONE, OP_LOAD, OP_ADD, OP_SUB} mac_op_t;

  // saturation helpers
  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'sh7FFFFFFF;
    else if (x < -50'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
    if (x > 50'sd32767) return 16'sh7FFF;
    else if (x < -50'sd32768) return 16'sh8000;
    else return x[15:0];
  endfunction

  function automatic logic signed [25:0] sat26(input logic signed [26:0] x);
    if (x > 27'sd33554431) return 26'sh1FFFFFF;
    else if (x < -27'sd33554432) return 26'sh2000000;
    else return x[25:0];
  endfunction

  function automatic logic signed [48:0] sat49(input logic signed [69:0] x);
    if (x > 70'sd281474976710655) return 49'sh0FFFFFFFFFFFF;
    else if (x < -70'sd281474976710656) return 49'sh1000000000000;
    else return x[48:0];
  endfunction

  function automatic logic [48:0] abs49(input logic signed [48:0] x);
    return x[48] ? (~x + 49'd1) : x;
  endfunction

  // configuration
  logic signed [23:0] bpf_gain, bpf_fb_one, bpf_fb_two;
  logic [47:0] mark_rotation, space_rotation, mark_wrap_fix, space_wrap_fix;
  logic [23:0] pll_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpf_gain       <= '0;
      bpf_fb_one     <= '0;
      bpf_fb_two     <= '0;
      mark_rotation  <= '0;
      space_rotation <= '0;
      mark_wrap_fix  <= '0;
      space_wrap_fix <= '0;
      pll_step       <= afsk_pkg::PLL_STEP_RESET;
    end else if (cfg_we) begin
      unique case (afsk_pkg::cfg_idx_t'(cfg_index))
        afsk_pkg::CFG_BPF_GAIN:       bpf_gain       <= cfg_data[23:0];
        afsk_pkg::CFG_BPF_FB_ONE:     bpf_fb_one     <= cfg_data[23:0];
        afsk_pkg::CFG_BPF_FB_TWO:     bpf_fb_two     <= cfg_data[23:0];
        afsk_pkg::CFG_MARK_ROTATION:  mark_rotation  <= cfg_data[47:0];
        afsk_pkg::CFG_SPACE_ROTATION: space_rotation <= cfg_data[47:0];
        afsk_pkg::CFG_MARK_WRAP_FIX:  mark_wrap_fix  <= cfg_data[47:0];
        afsk_pkg::CFG_SPACE_WRAP_FIX: space_wrap_fix <= cfg_data[47:0];
        afsk_pkg::CFG_PLL_STEP:       pll_step       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  logic signed [23:0] m_tr, m_ti, m_wr, m_wi, s_tr, s_ti, s_wr, s_wi;
  assign m_tr = mark_rotation[47:24];
  assign m_ti = mark_rotation[23:0];
  assign m_wr = mark_wrap_fix[47:24];
  assign m_wi = mark_wrap_fix[23:0];
  assign s_tr = space_rotation[47:24];
  assign s_ti = space_rotation[23:0];
  assign s_wr = space_wrap_fix[47:24];
  assign s_wi = space_wrap_fix[23:0];

  localparam int QUO_W_L = afsk_pkg::QUO_W;

  // state
  state_t state;
  logic [4:0] step;
  logic signed [15:0] s_reg, x_old, y_reg;
  logic signed [31:0] d1, d2, w_reg;
  logic signed [31:0] mre, mim, sre, sim;
  logic [POS_W-1:0] pos;
  logic [FILL_W-1:0] fill_count;
  logic wrapped;
  logic signed [48:0] soft_val, mid_value, last_value;
  logic mid_taken;
  logic signed [25:0] phase;
  logic [48:0] den, rem;
  logic [QUO_W_L-1:0] quo;
  logic nudge_add;
  logic out_valid, out_bit;
  logic emit_go;

  // shared multiplier and accumulator
  logic signed [32:0] mul_a, mul_b;
  mac_op_t mul_op, prod_op;
  logic signed [65:0] prod;
  logic signed [69:0] acc, acc_rnd_full;
  logic signed [47:0] rnd;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_op = OP_NONE;
    if (state == ST_RUN) begin
      unique case (step)
        5'd0:  begin mul_a = 33'(bpf_fb_one); mul_b = 33'(d1); mul_op = OP_LOAD; end
        5'd1:  begin mul_a = 33'(bpf_fb_two); mul_b = 33'(d2); mul_op = OP_ADD; end
        5'd4:  begin mul_a = 33'(bpf_gain); mul_b = 33'(w_reg) - 33'(d2); mul_op = OP_LOAD; end
        5'd7:  begin mul_a = 33'(m_tr); mul_b = 33'(mre); mul_op = OP_LOAD; end
        5'd8:  begin mul_a = 33'(m_ti); mul_b = 33'(mim); mul_op = OP_SUB; end
        5'd9:  begin mul_a = 33'(x_old); mul_b = 33'(m_wr); mul_op = OP_SUB; end
        5'd10: begin mul_a = 33'(m_ti); mul_b = 33'(mre); mul_op = OP_LOAD; end
        5'd11: begin mul_a = 33'(m_tr); mul_b = 33'(mim); mul_op = OP_ADD; end
        5'd12: begin mul_a = 33'(x_old); mul_b = 33'(m_wi); mul_op = OP_SUB; end
        5'd13: begin mul_a = 33'(s_tr); mul_b = 33'(sre); mul_op = OP_LOAD; end
        5'd14: begin mul_a = 33'(s_ti); mul_b = 33'(sim); mul_op = OP_SUB; end
        5'd15: begin mul_a = 33'(x_old); mul_b = 33'(s_wr); mul_op = OP_SUB; end
        5'd16: begin mul_a = 33'(s_ti); mul_b = 33'(sre); mul_op = OP_LOAD; end
        5'd17: begin mul_a = 33'(s_tr); mul_b = 33'(sim); mul_op = OP_ADD; end
        5'd18: begin mul_a = 33'(x_old); mul_b = 33'(s_wi); mul_op = OP_SUB; end
        5'd19: begin mul_a = 33'(mre); mul_b = 33'(mre); mul_op = OP_LOAD; end
        5'd20: begin mul_a = 33'(mim); mul_b = 33'(mim); mul_op = OP_ADD; end
        5'd21: begin mul_a = 33'(sre); mul_b = 33'(sre); mul_op = OP_SUB; end
        5'd22: begin mul_a = 33'(sim); mul_b = 33'(sim); mul_op = OP_SUB; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= OP_NONE;
    end else begin
      prod_op <= mul_op;
    end
    prod <= mul_a * mul_b;
    unique case (prod_op)
      OP_LOAD: acc <= 70'(prod);
      OP_ADD:  acc <= acc + 70'(prod);
      OP_SUB:  acc <= acc - 70'(prod);
      OP_NONE: ;
      default: ;
    endcase
  end

  // round half up by 2^22
  assign acc_rnd_full = (acc + 70'sd2097152) >>> 22;
  assign rnd = acc_rnd_full[47:0];

  // window memory
  logic ram_we;
  logic [15:0] ram_rdata;
  logic signed [15:0] y_next;

  assign y_next = sat16(50'(rnd));
  assign ram_we = (state == ST_RUN) && (step == STEP_Y);

  afsk_ram #(.WIDTH(afsk_pkg::SAMPLE_W), .DEPTH(L)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (y_next),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  // timing loop, evaluated in ST_LOOP, ST_DIV and ST_CORR
  logic signed [25:0] ph_add;
  logic mid_set, wrap, prev_pos, cur_pos, nudge;
  logic signed [48:0] mid_new;
  logic [48:0] abs_last, abs_soft, den_new, num_new;
  logic [49:0] rem_shift;
  logic [41:0] corr_prod;
  logic [25:0] corr;
  logic signed [25:0] ph_corr;

  always_comb begin
    ph_add   = sat26(27'(phase) + 27'({3'b0, pll_step}));
    mid_set  = !mid_taken && (27'(ph_add) >= HALF_Q24);
    mid_new  = mid_set ? soft_val : mid_value;
    wrap     = 27'(ph_add) >= ONE_Q24;
    prev_pos = last_value > 49'sd0;
    cur_pos  = soft_val > 49'sd0;
    abs_last = abs49(last_value);
    abs_soft = abs49(soft_val);
    den_new  = (abs_last > abs_soft) ? abs_last : abs_soft;
    num_new  = abs49(mid_new);
    nudge    = (prev_pos != cur_pos) && (mid_new != 49'sd0) && (den_new != 49'd0);
    rem_shift = {rem, 1'b0};
    corr_prod = 42'(quo) * 42'(GAIN);
    corr      = corr_prod[41:16];
    ph_corr   = nudge_add ? sat26(27'(phase) + 27'({1'b0, corr}))
                          : sat26(27'(phase) - 27'({1'b0, corr}));
  end

  assign samples.ready = (state == ST_IDLE);
  assign bits.valid    = out_valid;
  assign bits.bit_res  = out_bit;
  assign emit_go       = (state == ST_EMIT) && (!out_valid || bits.ready);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_bit   <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
      out_bit   <= soft_val > 49'sd0;
    end else if (bits.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      d1         <= '0;
      d2         <= '0;
      mre        <= '0;
      mim        <= '0;
      sre        <= '0;
      sim        <= '0;
      pos        <= '0;
      fill_count <= '0;
      wrapped    <= 1'b0;
      phase      <= '0;
      mid_value  <= '0;
      mid_taken  <= 1'b0;
      last_value <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            s_reg <= samples.sample;
            step  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          if (step == 5'd0) begin
            x_old <= wrapped ? ram_rdata : 16'sd0;
          end
          if (step == STEP_W) begin
            w_reg <= sat32(50'(s_reg) - 50'(rnd));
          end
          if (step == STEP_Y) begin
            y_reg <= y_next;
            d2    <= d1;
            d1    <= w_reg;
            if (pos == POS_W'(L - 1)) begin
              pos     <= '0;
              wrapped <= 1'b1;
            end else begin
              pos <= pos + POS_W'(1);
            end
          end
          if (step == STEP_MRE) mre <= sat32(50'(rnd) + 50'(y_reg));
          if (step == STEP_MIM) mim <= sat32(50'(rnd));
          if (step == STEP_SRE) sre <= sat32(50'(rnd) + 50'(y_reg));
          if (step == STEP_SIM) sim <= sat32(50'(rnd));
          if (step == STEP_SOFT) begin
            soft_val <= sat49(acc);
            state    <= ST_LOOP;
          end
        end
        ST_LOOP: begin
          if (fill_count != FILL_W'(L - 1)) begin
            fill_count <= fill_count + FILL_W'(1);
            state      <= ST_IDLE;
          end else begin
            mid_value <= mid_new;
            if (!wrap) begin
              phase     <= ph_add;
              mid_taken <= mid_taken | mid_set;
              state     <= ST_IDLE;
            end else begin
              phase     <= ph_add - 26'sd16777216;
              mid_taken <= 1'b0;
              nudge_add <= (mid_new > 49'sd0) == prev_pos;
              den       <= den_new;
              rem       <= num_new;
              quo       <= (nudge && (num_new >= den_new)) ?
                           (QUO_W_L'(1) << afsk_pkg::DIV_STEPS) : '0;
              step      <= '0;
              if (!nudge) begin
                state <= ST_EMIT;
              end else if (num_new >= den_new) begin
                state <= ST_CORR;
              end else begin
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (rem_shift >= 50'(den)) begin
            rem <= 49'(rem_shift - 50'(den));
            quo <= {quo[QUO_W_L-2:0], 1'b1};
          end else begin
            rem <= rem_shift[48:0];
            quo <= {quo[QUO_W_L-2:0], 1'b0};
          end
          step <= step + 5'd1;
          if (step == DIV_LAST) begin
            state <= ST_CORR;
          end
        end
        ST_CORR: begin
          phase <= ph_corr;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            last_value <= soft_val;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> step <= STEP_SOFT)
    else $error("run step past last multiplier step");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> step <= DIV_LAST)
    else $error("divider ran past its steps");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(L - 1))
    else $error("window position out of range");

  a_emit_filled: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> fill_count == FILL_W'(L - 1))
    else $error("bit emitted before window filled");

  a_mid_filled: assert property (@(posedge clk) disable iff (rst)
    fill_count != FILL_W'(L - 1) |-> !mid_taken)
    else $error("mid-bit capture while filling");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < den)
    else $error("divider remainder not below divisor");

endmodule

// File: test/tb_afsk_sdft_demodulator.sv
// ----------------------------------------------------------------------------
// tb_afsk_sdft_demodulator
// Self-checking bench for the AFSK demodulator: FSK tone bursts, noise and
// extreme coefficient sets are fed in with random gaps and stalls, and every
// decided bit is compared with an in-bench bit-exact model of the datapath.
// ----------------------------------------------------------------------------
module tb_afsk_sdft_demodulator;

  localparam int  TIMEOUT_CYCLES = 1_000_000;
  localparam int  SETTLE_CYCLES  = 120;
  localparam int  HOLD_CYCLES    = 4000;
  localparam real FS             = 48000.0;
  localparam real PI             = 3.14159265358979;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [afsk_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [afsk_pkg::CFG_DATA_W-1:0] cfg_data;

  afsk_sample_if sample_ch ();
  afsk_bit_if    bit_ch ();

  afsk_sdft_demodulator i_dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_ch),
    .bits      (bit_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model copy of the registers
  logic signed [afsk_pkg::COEF_W-1:0] m_gain, m_fb1, m_fb2;
  logic [afsk_pkg::ROT_W-1:0]  m_mark_rot, m_space_rot, m_mark_fix, m_space_fix;
  logic [afsk_pkg::COEF_W-1:0] m_step;

  // model copy of the state
  longint m_d1, m_d2;
  longint m_win [afsk_pkg::WINDOW_LEN];
  int     m_pos, m_fill;
  longint m_bin [4];
  longint m_phase, m_mid, m_last;
  bit     m_mid_taken;

  logic signed [afsk_pkg::SAMPLE_W-1:0] pending_samples [$];
  bit                                   expected_bits [$];

  int  err_count, samples_in, bits_out, cycle_count;
  int  tx_gap, rx_gap, hold_left;
  bit  no_idle, long_hold_go, hold_done;

  function automatic longint sat_to(longint x, int w);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    if (x >= lim) return lim - 1;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic longint rnd22(longint x);
    return (x + (longint'(1) <<< 21)) >>> 22;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic rotate_bin(int k, logic [afsk_pkg::ROT_W-1:0] rot,
                            logic [afsk_pkg::ROT_W-1:0] fix,
                            longint y, longint x_old);
    longint tr, ti, wr, wi, r, i;
    tr = longint'($signed(rot[47:24]));
    ti = longint'($signed(rot[23:0]));
    wr = longint'($signed(fix[47:24]));
    wi = longint'($signed(fix[23:0]));
    r  = m_bin[k];
    i  = m_bin[k+1];
    m_bin[k]   = sat_to(rnd22(tr * r - ti * i - x_old * wr) + y, afsk_pkg::BIN_W);
    m_bin[k+1] = sat_to(rnd22(ti * r + tr * i - x_old * wi), afsk_pkg::BIN_W);
  endtask

  // bit-exact prediction of one sample; queues a bit when one is due
  task automatic predict_bit(logic signed [afsk_pkg::SAMPLE_W-1:0] s);
    longint w, y, x_old, soft_v, al, ac;
    longint unsigned pm, ps, d, den, num, q, r, corr;
    bit prev_pos, cur_pos, add;
    w = sat_to(longint'(s) - rnd22(longint'(m_fb1) * m_d1 + longint'(m_fb2) * m_d2),
               afsk_pkg::DELAY_W);
    y = sat_to(rnd22(longint'(m_gain) * (w - m_d2)), afsk_pkg::SAMPLE_W);
    m_d2 = m_d1;
    m_d1 = w;
    x_old = m_win[m_pos];
    m_win[m_pos] = y;
    m_pos = (m_pos + 1 >= afsk_pkg::WINDOW_LEN) ? 0 : m_pos + 1;
    rotate_bin(0, m_mark_rot, m_mark_fix, y, x_old);
    rotate_bin(2, m_space_rot, m_space_fix, y, x_old);
    pm = m_bin[0] * m_bin[0] + m_bin[1] * m_bin[1];
    ps = m_bin[2] * m_bin[2] + m_bin[3] * m_bin[3];
    if (pm >= ps) begin
      d = pm - ps;
      soft_v = (d > 64'hFFFF_FFFF_FFFF) ? 64'sh0000_FFFF_FFFF_FFFF : longint'(d);
    end else begin
      d = ps - pm;
      soft_v = (d > 64'h1_0000_0000_0000) ? -64'sh1_0000_0000_0000 : -longint'(d);
    end
    if (m_fill < afsk_pkg::WINDOW_LEN - 1) begin
      m_fill++;
      return;
    end
    m_phase = sat_to(m_phase + longint'(m_step), afsk_pkg::PHASE_W);
    if (!m_mid_taken && m_phase >= (longint'(1) <<< 23)) begin
      m_mid = soft_v;
      m_mid_taken = 1;
    end
    if (m_phase < (longint'(1) <<< 24)) return;
    m_phase -= longint'(1) <<< 24;
    m_mid_taken = 0;
    prev_pos = m_last > 0;
    cur_pos  = soft_v > 0;
    if (prev_pos != cur_pos && m_mid != 0) begin
      al  = (m_last < 0) ? -m_last : m_last;
      ac  = (soft_v < 0) ? -soft_v : soft_v;
      den = (al > ac) ? al : ac;
      num = (m_mid < 0) ? -m_mid : m_mid;
      if (den != 0) begin
        q = 0;
        r = num;
        if (num >= den) q = 64'd1 << 25;
        else begin
          for (int k = 0; k < afsk_pkg::DIV_STEPS; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
              r -= den;
              q |= 1;
            end
          end
        end
        corr = (longint'(afsk_pkg::LOOP_GAIN) * q) >> 16;
        add  = (m_mid > 0) == prev_pos;
        m_phase = sat_to(add ? m_phase + longint'(corr) : m_phase - longint'(corr),
                         afsk_pkg::PHASE_W);
      end
    end
    m_last = soft_v;
    expected_bits.push_back(soft_v > 0);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
             what, cycle_count, got, want);
    err_count++;
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("timeout: %0d bits still expected", expected_bits.size());
      $display("[afsk_sdft_demodulator] ERROR");
      $finish;
    end
  end

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid  <= 0;
      sample_ch.sample <= '0;
      tx_gap <= 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        predict_bit(sample_ch.sample);
        samples_in++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          sample_ch.valid <= 0;
        end else if (pending_samples.size() != 0) begin
          sample_ch.valid  <= 1;
          sample_ch.sample <= pending_samples.pop_front();
          tx_gap <= pick_gap();
        end else begin
          sample_ch.valid <= 0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (long_hold_go && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      bit_ch.ready <= 0;
      rx_gap <= 0;
    end else if (hold_left != 0) begin
      bit_ch.ready <= 0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      bit_ch.ready <= 0;
    end else begin
      bit_ch.ready <= 1;
      if (bit_ch.valid && bit_ch.ready) rx_gap <= pick_gap();
    end
  end

  // bit monitor
  always @(posedge clk) begin
    if (!rst && bit_ch.valid && bit_ch.ready) begin
      bits_out++;
      if (expected_bits.size() == 0) report_mismatch("unexpected bit", bit_ch.bit_res, -1);
      else begin
        if (bit_ch.bit_res !== expected_bits[0])
          report_mismatch("bit_res", bit_ch.bit_res, expected_bits[0]);
        void'(expected_bits.pop_front());
      end
    end
  end

  task automatic write_reg(afsk_pkg::cfg_idx_t idx, logic [afsk_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      afsk_pkg::CFG_BPF_GAIN:       m_gain      = value[afsk_pkg::COEF_W-1:0];
      afsk_pkg::CFG_BPF_FB_ONE:     m_fb1       = value[afsk_pkg::COEF_W-1:0];
      afsk_pkg::CFG_BPF_FB_TWO:     m_fb2       = value[afsk_pkg::COEF_W-1:0];
      afsk_pkg::CFG_MARK_ROTATION:  m_mark_rot  = value;
      afsk_pkg::CFG_SPACE_ROTATION: m_space_rot = value;
      afsk_pkg::CFG_MARK_WRAP_FIX:  m_mark_fix  = value;
      afsk_pkg::CFG_SPACE_WRAP_FIX: m_space_fix = value;
      afsk_pkg::CFG_PLL_STEP:       m_step      = value[afsk_pkg::COEF_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [afsk_pkg::COEF_W-1:0] to_q22(real x);
    longint v, t;
    v = longint'(x * 4194304.0);
    t = sat_to(v, afsk_pkg::COEF_W);
    return t[afsk_pkg::COEF_W-1:0];
  endfunction

  function automatic logic [afsk_pkg::ROT_W-1:0] cplx(real ang);
    return {to_q22($cos(ang)), to_q22($sin(ang))};
  endfunction

  // band-pass around the tones and twiddles for 1200 / 2200 Hz bins
  task automatic load_tone_setup(logic [afsk_pkg::COEF_W-1:0] step);
    real km, ks, w0;
    km = 1200.0 * afsk_pkg::WINDOW_LEN / FS;
    ks = 2200.0 * afsk_pkg::WINDOW_LEN / FS;
    w0 = 2.0 * PI * 1700.0 / FS;
    write_reg(afsk_pkg::CFG_BPF_GAIN, {24'd0, to_q22(0.08)});
    write_reg(afsk_pkg::CFG_BPF_FB_ONE, {24'd0, to_q22(-2.0 * 0.9 * $cos(w0))});
    write_reg(afsk_pkg::CFG_BPF_FB_TWO, {24'd0, to_q22(0.81)});
    write_reg(afsk_pkg::CFG_MARK_ROTATION, cplx(2.0 * PI * km / afsk_pkg::WINDOW_LEN));
    write_reg(afsk_pkg::CFG_SPACE_ROTATION, cplx(2.0 * PI * ks / afsk_pkg::WINDOW_LEN));
    write_reg(afsk_pkg::CFG_MARK_WRAP_FIX, cplx(2.0 * PI * km));
    write_reg(afsk_pkg::CFG_SPACE_WRAP_FIX, cplx(2.0 * PI * ks));
    write_reg(afsk_pkg::CFG_PLL_STEP, {24'd0, step});
  endtask

  task automatic random_setup(logic [afsk_pkg::COEF_W-1:0] step);
    write_reg(afsk_pkg::CFG_BPF_GAIN, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_BPF_FB_ONE, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_BPF_FB_TWO, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_MARK_ROTATION, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_SPACE_ROTATION, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_MARK_WRAP_FIX, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_SPACE_WRAP_FIX, 48'({$urandom, $urandom}));
    write_reg(afsk_pkg::CFG_PLL_STEP, {24'd0, step});
  endtask

  // fsk bursts with random data, amplitude and a little noise
  task automatic queue_fsk(int count, int per_bit);
    real ph, amp, f;
    int  v, left;
    ph = 0.0;
    left = 0;
    f = 1200.0;
    amp = 0.0;
    for (int n = 0; n < count; n++) begin
      if (left == 0) begin
        f = ($urandom_range(1) != 0) ? 1200.0 : 2200.0;
        amp = real'($urandom_range(32000, 800));
        left = per_bit;
      end
      left--;
      ph += 2.0 * PI * f / FS;
      v = int'(amp * $sin(ph)) + int'($urandom_range(400)) - 200;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      pending_samples.push_back(v[afsk_pkg::SAMPLE_W-1:0]);
    end
  endtask

  task automatic queue_noise(int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(9);
      if (r == 0) pending_samples.push_back(16'sh7FFF);
      else if (r == 1) pending_samples.push_back(16'sh8000);
      else pending_samples.push_back(16'($urandom));
    end
  endtask

  // all samples taken, every bit back, then let the block settle
  task automatic drain();
    while (pending_samples.size() != 0 || sample_ch.valid || expected_bits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    m_gain = '0; m_fb1 = '0; m_fb2 = '0;
    m_mark_rot = '0; m_space_rot = '0; m_mark_fix = '0; m_space_fix = '0;
    m_step = afsk_pkg::PLL_STEP_RESET;
    m_d1 = 0; m_d2 = 0; m_pos = 0; m_fill = 0;
    foreach (m_win[k]) m_win[k] = 0;
    foreach (m_bin[k]) m_bin[k] = 0;
    m_phase = 0; m_mid = 0; m_last = 0; m_mid_taken = 0;
    err_count = 0; samples_in = 0; bits_out = 0; cycle_count = 0;
    no_idle = 0;
    long_hold_go = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // reset coefficients: sample extremes and the start of the window fill, too few for a bit
    pending_samples.push_back(16'sh7FFF);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(16'sh0000);
    pending_samples.push_back(16'shFFFF);
    pending_samples.push_back(16'sh0001);
    queue_noise(20);
    drain();

    // hot filter, extreme gain, a bit on nearly every sample
    write_reg(afsk_pkg::CFG_BPF_GAIN, 48'h7F_FFFF);
    write_reg(afsk_pkg::CFG_BPF_FB_ONE, 48'h80_0000);
    write_reg(afsk_pkg::CFG_BPF_FB_TWO, 48'h7F_FFFF);
    write_reg(afsk_pkg::CFG_PLL_STEP, 48'hFF_FFFF);
    queue_noise(80);
    drain();

    // clean tones, nominal rate; receiver holds off so the block backs up
    load_tone_setup(afsk_pkg::PLL_STEP_RESET);
    long_hold_go = 1;
    queue_fsk(600, 40);
    drain();

    no_idle = 1;
    load_tone_setup(24'd1677722);
    queue_fsk(300, 10);
    drain();
    no_idle = 0;

    load_tone_setup(24'd3355443);
    queue_fsk(250, 5);
    drain();

    // zero step: loop never advances
    write_reg(afsk_pkg::CFG_PLL_STEP, '0);
    queue_noise(60);
    drain();

    random_setup(24'hFF_FFFF);
    write_reg(afsk_pkg::CFG_BPF_GAIN, 48'h80_0000);
    queue_noise(200);
    drain();

    for (int p = 0; p < 3; p++) begin
      random_setup(24'($urandom_range(24'd4000000, 24'd300000)));
      queue_noise(110);
      drain();
    end

    $display("fed %0d samples over tone, noise and extreme coefficient sets", samples_in);
    $display("checked %0d decided bits, %0d mismatches", bits_out, err_count);
    if (err_count == 0) begin
      $display("[afsk_sdft_demodulator] OK");
    end else begin
      $display("[afsk_sdft_demodulator] ERROR");
    end
    $finish;
  end

endmodule
